// ----- hw/rtl/pcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Polynomial coefficient multiply: shared definitions
// Widths, types and defaults used by the sequencer, the cells and the
// output stage.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int COEF_W        = 32;
    localparam int PROD_W        = 64;
    localparam int POW_W         = 6;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic              we_first;
        logic              we_second;
        logic [COEF_W-1:0] coef;
    } t_cell_wr;

    typedef struct packed {
        logic             valid;
        logic [POW_W-1:0] power;
        logic             last;
    } t_tag;

endpackage

// ----- hw/rtl/polynomial_coefficient_multiply.sv -----
// Pipeline: after the request that closes both lists, the first product passes the state,
// x and tag, product, sum and output registers; the rest follow one per cycle while the
// output is taken. Throughput: a new request is taken every cycle while loading; no request
// is taken until all n1+n2-1 results of a run have been taken downstream.
// Reset (synchronous, active low) clears counts, flags and the pipeline; the stored
// coefficients are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
// Polynomial coefficient multiply
// Convolves two streamed coefficient lists with a row of systolic cells and
// streams out the saturated Q32.32 product coefficients.
// ----------------------------------------------------------------------------
module polynomial_coefficient_multiply #(
    parameter int MAX_TERMS = pcm_pkg::MAX_TERMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] coef_value
    input  logic        s_axis_tlast,   // list_end
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] product_coef, [69:64] power_index, rest zero
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // [0] overflow_flag
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int ACC_W = pcm_pkg::PROD_W + IDX_W;

    logic                              w_adv;
    logic                              w_run_done;
    logic                              w_shift;
    pcm_pkg::t_cell_wr                 w_wr;
    logic [IDX_W-1:0]                  w_wr_addr;
    logic [CNT_W-1:0]                  w_n1;
    logic signed [pcm_pkg::COEF_W-1:0] w_x;
    pcm_pkg::t_tag                     w_tag;
    logic                              w_dropped;
    logic signed [pcm_pkg::COEF_W-1:0] w_b   [MAX_TERMS+1];
    logic signed [ACC_W-1:0]           w_acc [MAX_TERMS+1];
    logic [pcm_pkg::PROD_W-1:0]        w_coef;
    logic [pcm_pkg::POW_W-1:0]         w_power;

    assign w_b[MAX_TERMS]   = '0;
    assign w_acc[MAX_TERMS] = '0;
    assign w_run_done       = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    pcm_seq #(
        .MAX_TERMS (MAX_TERMS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_sel      (s_axis_tuser),
        .i_coef     (s_axis_tdata),
        .i_end      (s_axis_tlast),
        .o_ready    (s_axis_tready),
        .i_adv      (w_adv),
        .i_run_done (w_run_done),
        .i_b0       (w_b[0]),
        .o_x        (w_x),
        .o_shift    (w_shift),
        .o_wr       (w_wr),
        .o_wr_addr  (w_wr_addr),
        .o_n1       (w_n1),
        .o_tag      (w_tag),
        .o_dropped  (w_dropped)
    );

    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        pcm_cell #(
            .MAX_TERMS (MAX_TERMS),
            .IDX       (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_shift    (w_shift),
            .i_wr       (w_wr),
            .i_wr_addr  (w_wr_addr),
            .i_n1       (w_n1),
            .i_x        (w_x),
            .i_b_next   (w_b[g+1]),
            .i_acc_next (w_acc[g+1]),
            .o_b        (w_b[g]),
            .o_acc      (w_acc[g])
        );
    end

    pcm_out #(
        .MAX_TERMS (MAX_TERMS)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc[0]),
        .i_tag     (w_tag),
        .i_dropped (w_dropped),
        .i_ready   (m_axis_tready),
        .o_adv     (w_adv),
        .o_valid   (m_axis_tvalid),
        .o_coef    (w_coef),
        .o_power   (w_power),
        .o_last    (m_axis_tlast),
        .o_ovf     (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, w_power, w_coef};

endmodule

// ----- hw/rtl/pcm_cell.sv -----
// ----------------------------------------------------------------------------
// Polynomial coefficient multiply: convolution cell
// Holds one coefficient of each polynomial. The second polynomial shifts
// down the row, and the partial sums move towards cell zero.
// ----------------------------------------------------------------------------
module pcm_cell #(
    parameter int MAX_TERMS = pcm_pkg::MAX_TERMS_DEF,
    parameter int IDX       = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_shift,
    input  pcm_pkg::t_cell_wr                     i_wr,
    input  logic [$clog2(MAX_TERMS)-1:0]          i_wr_addr,
    input  logic [$clog2(MAX_TERMS+1)-1:0]        i_n1,
    input  logic signed [pcm_pkg::COEF_W-1:0]     i_x,
    input  logic signed [pcm_pkg::COEF_W-1:0]     i_b_next,
    input  logic signed [pcm_pkg::PROD_W+$clog2(MAX_TERMS)-1:0] i_acc_next,
    output logic signed [pcm_pkg::COEF_W-1:0]     o_b,
    output logic signed [pcm_pkg::PROD_W+$clog2(MAX_TERMS)-1:0] o_acc
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int ACC_W = pcm_pkg::PROD_W + IDX_W;

    logic signed [pcm_pkg::COEF_W-1:0] r_a;
    logic signed [pcm_pkg::COEF_W-1:0] r_b;
    logic signed [pcm_pkg::PROD_W-1:0] r_p;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [pcm_pkg::PROD_W-1:0] w_prod;
    logic                              w_hit;
    logic                              w_active;

    assign w_hit    = (i_wr_addr == IDX_W'(IDX));
    assign w_active = (CNT_W'(IDX) < i_n1);
    assign w_prod   = r_a * i_x;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_first && w_hit) begin
            r_a <= i_wr.coef;
        end
        if (i_wr.we_second && w_hit) begin
            r_b <= i_wr.coef;
        end else if (i_shift) begin
            r_b <= i_b_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p   <= '0;
            r_acc <= '0;
        end else if (i_adv) begin
            r_p   <= w_active ? w_prod : '0;
            r_acc <= {{(ACC_W-pcm_pkg::PROD_W){r_p[pcm_pkg::PROD_W-1]}}, r_p} + i_acc_next;
        end
    end

    assign o_b   = r_b;
    assign o_acc = r_acc;

endmodule

// ----- hw/rtl/pcm_seq.sv -----
// ----------------------------------------------------------------------------
// Polynomial coefficient multiply: sequencer
// Takes in both coefficient lists, then feeds the second list through the
// cell row and tags each result with its power and the last mark.
// ----------------------------------------------------------------------------
module pcm_seq #(
    parameter int MAX_TERMS = pcm_pkg::MAX_TERMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_sel,
    input  logic [pcm_pkg::COEF_W-1:0]         i_coef,
    input  logic                               i_end,
    output logic                               o_ready,
    input  logic                               i_adv,
    input  logic                               i_run_done,
    input  logic signed [pcm_pkg::COEF_W-1:0]  i_b0,
    output logic signed [pcm_pkg::COEF_W-1:0]  o_x,
    output logic                               o_shift,
    output pcm_pkg::t_cell_wr                  o_wr,
    output logic [$clog2(MAX_TERMS)-1:0]       o_wr_addr,
    output logic [$clog2(MAX_TERMS+1)-1:0]     o_n1,
    output pcm_pkg::t_tag                      o_tag,
    output logic                               o_dropped
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int K_W   = ($clog2(2 * MAX_TERMS) > pcm_pkg::POW_W) ?
                           $clog2(2 * MAX_TERMS) : pcm_pkg::POW_W;

    pcm_pkg::t_state                   r_state, n_state;
    logic [CNT_W-1:0]                  r_cnt1, n_cnt1;
    logic [CNT_W-1:0]                  r_cnt2, n_cnt2;
    logic                              r_done1, n_done1;
    logic                              r_done2, n_done2;
    logic                              r_drop, n_drop;
    logic [K_W-1:0]                    r_k, n_k;
    logic signed [pcm_pkg::COEF_W-1:0] r_x, n_x;
    pcm_pkg::t_tag                     r_tag0, n_tag0;
    pcm_pkg::t_tag                     r_tag1;
    pcm_pkg::t_tag                     r_tag2;
    logic                              w_accept;
    logic [K_W-1:0]                    w_total;
    logic                              w_last;

    assign o_ready  = (r_state == pcm_pkg::ST_LOAD);
    assign w_accept = i_valid && o_ready;
    assign w_total  = K_W'(r_cnt1) + K_W'(r_cnt2) - K_W'(1);
    assign w_last   = (r_k == w_total - K_W'(1));

    always_comb begin
        n_state   = r_state;
        n_cnt1    = r_cnt1;
        n_cnt2    = r_cnt2;
        n_done1   = r_done1;
        n_done2   = r_done2;
        n_drop    = r_drop;
        n_k       = r_k;
        n_x       = r_x;
        n_tag0    = r_tag0;
        o_wr      = '0;
        o_wr.coef = i_coef;
        o_wr_addr = i_sel ? r_cnt2[IDX_W-1:0] : r_cnt1[IDX_W-1:0];
        o_shift   = 1'b0;
        if (i_adv) begin
            n_x    = '0;
            n_tag0 = '0;
        end
        unique case (r_state)
            pcm_pkg::ST_LOAD: begin
                n_k = '0;
                if (w_accept && !i_sel && !r_done1) begin
                    if (r_cnt1 < CNT_W'(MAX_TERMS)) begin
                        o_wr.we_first = 1'b1;
                        n_cnt1        = r_cnt1 + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_done1 = i_end;
                end
                if (w_accept && i_sel && !r_done2) begin
                    if (r_cnt2 < CNT_W'(MAX_TERMS)) begin
                        o_wr.we_second = 1'b1;
                        n_cnt2         = r_cnt2 + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_done2 = i_end;
                end
                if (n_done1 && n_done2) begin
                    n_state = pcm_pkg::ST_RUN;
                end
            end
            pcm_pkg::ST_RUN: begin
                if (i_adv) begin
                    o_shift      = 1'b1;
                    n_x          = (r_k < K_W'(r_cnt2)) ? i_b0 : '0;
                    n_tag0.valid = 1'b1;
                    n_tag0.power = r_k[pcm_pkg::POW_W-1:0];
                    n_tag0.last  = w_last;
                    n_k          = r_k + K_W'(1);
                    if (w_last) begin
                        n_state = pcm_pkg::ST_DRAIN;
                    end
                end
            end
            pcm_pkg::ST_DRAIN: begin
                if (i_run_done) begin
                    n_state = pcm_pkg::ST_LOAD;
                    n_cnt1  = '0;
                    n_cnt2  = '0;
                    n_done1 = 1'b0;
                    n_done2 = 1'b0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = pcm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcm_pkg::ST_LOAD;
            r_cnt1  <= '0;
            r_cnt2  <= '0;
            r_done1 <= 1'b0;
            r_done2 <= 1'b0;
            r_drop  <= 1'b0;
            r_k     <= '0;
            r_x     <= '0;
            r_tag0  <= '0;
            r_tag1  <= '0;
            r_tag2  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt1  <= n_cnt1;
            r_cnt2  <= n_cnt2;
            r_done1 <= n_done1;
            r_done2 <= n_done2;
            r_drop  <= n_drop;
            r_k     <= n_k;
            r_x     <= n_x;
            r_tag0  <= n_tag0;
            if (i_adv) begin
                r_tag1 <= r_tag0;
                r_tag2 <= r_tag1;
            end
        end
    end

    assign o_x       = r_x;
    assign o_n1      = r_cnt1;
    assign o_tag     = r_tag2;
    assign o_dropped = r_drop;

endmodule

// ----- hw/rtl/pcm_out.sv -----
// ----------------------------------------------------------------------------
// Polynomial coefficient multiply: output stage
// Saturates the exact sum from cell zero to 64 bits and holds the result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module pcm_out #(
    parameter int MAX_TERMS = pcm_pkg::MAX_TERMS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic signed [pcm_pkg::PROD_W+$clog2(MAX_TERMS)-1:0] i_acc,
    input  pcm_pkg::t_tag                                     i_tag,
    input  logic                                              i_dropped,
    input  logic                                              i_ready,
    output logic                                              o_adv,
    output logic                                              o_valid,
    output logic [pcm_pkg::PROD_W-1:0]                        o_coef,
    output logic [pcm_pkg::POW_W-1:0]                         o_power,
    output logic                                              o_last,
    output logic                                              o_ovf
);

    localparam int ACC_W = pcm_pkg::PROD_W + $clog2(MAX_TERMS);
    localparam int TOP_W = ACC_W - pcm_pkg::PROD_W + 1;

    logic                        r_valid;
    logic [pcm_pkg::PROD_W-1:0]  r_coef;
    logic [pcm_pkg::POW_W-1:0]   r_power;
    logic                        r_last;
    logic                        r_ovf;
    logic [TOP_W-1:0]            w_top;
    logic                        w_sat;
    logic [pcm_pkg::PROD_W-1:0]  w_coef;

    assign w_top  = i_acc[ACC_W-1:pcm_pkg::PROD_W-1];
    assign w_sat  = !((w_top == '0) || (w_top == '1));
    assign w_coef = !w_sat ? i_acc[pcm_pkg::PROD_W-1:0] :
                    i_acc[ACC_W-1] ? {1'b1, {(pcm_pkg::PROD_W-1){1'b0}}} :
                                     {1'b0, {(pcm_pkg::PROD_W-1){1'b1}}};
    assign o_adv  = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_tag.valid) begin
            r_coef  <= w_coef;
            r_power <= i_tag.power;
            r_last  <= i_tag.last;
            r_ovf   <= w_sat || i_dropped;
        end
    end

    assign o_valid = r_valid;
    assign o_coef  = r_coef;
    assign o_power = r_power;
    assign o_last  = r_last;
    assign o_ovf   = r_ovf;

endmodule
